### rtl/core/serial_output_command_decoder_macros.svh
// Assertion macros for the serial output command decoder checker.
// No dependencies; included by the checker file.
`ifndef SERIAL_OUTPUT_COMMAND_DECODER_MACROS_SVH
`define SERIAL_OUTPUT_COMMAND_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SOCD_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SOCD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/socd_pkg.sv
// Package for the serial output command decoder: recognizer phase types,
// command characters and the status reply text. No dependencies.
`default_nettype none

package socd_pkg;

  // Command characters
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_SET  = 8'h41;
  localparam logic [7:0] CH_QRY  = 8'h57;
  localparam logic [7:0] CH_CR   = 8'h0D;

  // Status reply "*W--108" plus CR
  localparam int unsigned REPLY_LEN = 8;
  localparam logic [2:0] REPLY_LAST = 3'(REPLY_LEN - 1);

  // Set command recognizer: '*','A',channel,level,CR
  typedef enum logic [2:0] {
    SET_IDLE  = 3'd0,
    SET_STAR  = 3'd1,
    SET_CHAN  = 3'd2,
    SET_LEVEL = 3'd3,
    SET_TERM  = 3'd4
  } set_phase_t;

  // Query command recognizer: '*','W',CR
  typedef enum logic [1:0] {
    QRY_IDLE = 2'd0,
    QRY_STAR = 2'd1,
    QRY_TERM = 2'd2
  } query_phase_t;

  function automatic logic [7:0] reply_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h2A;
      3'd1:    b = 8'h57;
      3'd2:    b = 8'h2D;
      3'd3:    b = 8'h2D;
      3'd4:    b = 8'h31;
      3'd5:    b = 8'h30;
      3'd6:    b = 8'h38;
      default: b = 8'h0D;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/core/serial_output_command_decoder.sv
// Serial output command decoder, top level.
// Depends on socd_pkg.
`default_nettype none

// Takes one received byte per beat on the input channel and returns, per
// byte, one output beat carrying the six output bits (tx_valid low, last
// high), or, when the byte completes a "*W" CR status query while tx_ready
// is high, eight beats carrying the reply "*W--108" CR with last on the CR.
// Both recognizers update in the same cycle a byte is accepted, and the
// result sits in an output register, so a byte is accepted every cycle the
// output side takes its beat; a status reply occupies the output register
// for eight beats, during which the input is stalled. Output bits
// reset to zero.
module serial_output_command_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       tx_ready,
  // output channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [5:0]      out_bits,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic            last
);
  import socd_pkg::*;

  set_phase_t   set_phase, set_phase_next;
  query_phase_t query_phase, query_phase_next;
  logic [3:0]   sel_channel, sel_channel_next;
  logic         pending_level, pending_level_next;
  logic [5:0]   out_reg, out_reg_next;
  logic         reply_mode;
  logic [2:0]   beat_idx;

  logic         in_acc, out_take, fire;
  logic [1:0]   ch_off;

  // Handshake
  assign out_take = out_valid && !out_stall;
  assign in_stall = out_valid && !(out_take && last);
  assign in_acc   = in_valid && !in_stall;

  // Recognizer next state
  always_comb begin
    set_phase_next     = SET_IDLE;
    sel_channel_next   = sel_channel;
    pending_level_next = pending_level;
    case (set_phase)
      SET_STAR:  set_phase_next = (rx_byte == CH_SET) ? SET_CHAN : SET_IDLE;
      SET_CHAN: begin
        sel_channel_next = rx_byte[3:0];
        set_phase_next   = SET_LEVEL;
      end
      SET_LEVEL: begin
        pending_level_next = rx_byte[0];
        set_phase_next     = SET_TERM;
      end
      SET_TERM:  set_phase_next = SET_IDLE;
      default:   set_phase_next = (rx_byte == CH_STAR) ? SET_STAR : SET_IDLE;
    endcase

    query_phase_next = QRY_IDLE;
    case (query_phase)
      QRY_STAR: query_phase_next = (rx_byte == CH_QRY) ? QRY_TERM : QRY_IDLE;
      QRY_TERM: query_phase_next = QRY_IDLE;
      default:  query_phase_next = (rx_byte == CH_STAR) ? QRY_STAR : QRY_IDLE;
    endcase
  end

  // Recognizer outputs: output bit update and reply trigger
  always_comb begin
    // pair value: low two bits of channel minus two, same for both groups
    ch_off       = sel_channel[1:0] - 2'd2;
    out_reg_next = out_reg;
    if (set_phase == SET_TERM && rx_byte == CH_CR) begin
      case (sel_channel)
        4'd0:                      out_reg_next[0]   = pending_level;
        4'd1:                      out_reg_next[1]   = pending_level;
        4'd2, 4'd3, 4'd4, 4'd5:    out_reg_next[3:2] = ch_off;
        4'd6, 4'd7, 4'd8, 4'd9:    out_reg_next[5:4] = ch_off;
        default:                   out_reg_next      = out_reg;
      endcase
    end
    fire = (query_phase == QRY_TERM) && (rx_byte == CH_CR) && tx_ready;
  end

  // Recognizer state and output bits
  always_ff @(posedge clk) begin
    if (rst) begin
      set_phase     <= SET_IDLE;
      query_phase   <= QRY_IDLE;
      sel_channel   <= '0;
      pending_level <= 1'b0;
      out_reg       <= '0;
    end else if (in_acc) begin
      set_phase     <= set_phase_next;
      query_phase   <= query_phase_next;
      sel_channel   <= sel_channel_next;
      pending_level <= pending_level_next;
      out_reg       <= out_reg_next;
    end
  end

  // Output beat register and reply sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      reply_mode <= 1'b0;
      beat_idx   <= '0;
    end else if (in_acc) begin
      out_valid  <= 1'b1;
      reply_mode <= fire;
      beat_idx   <= '0;
    end else if (out_take) begin
      if (last) begin
        out_valid <= 1'b0;
      end else begin
        beat_idx <= beat_idx + 3'd1;
      end
    end
  end

  // Output payload
  assign out_bits = out_reg;
  assign tx_valid = reply_mode;
  assign tx_byte  = reply_mode ? reply_byte(beat_idx) : 8'h00;
  assign last     = !reply_mode || (beat_idx == REPLY_LAST);

endmodule

`default_nettype wire

### rtl/core/socd_checker.sv
// Port-level checker for the serial output command decoder, bound to it.
// Depends on serial_output_command_decoder_macros.svh.
`default_nettype none

`include "serial_output_command_decoder_macros.svh"

module socd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] tx_byte,
  input wire logic       tx_valid,
  input wire logic       last
);

  // every accepted byte yields a beat
  `SOCD_ASSERT_NEXT(a_acc_out, clk, rst, in_valid && !in_stall, out_valid, "accepted byte produced no beat")

  // a plain beat is a single last beat with no reply byte
  `SOCD_ASSERT_IMPL(a_plain, clk, rst, out_valid && !tx_valid, last && (tx_byte == 8'h00), "plain beat malformed")

  // a reply keeps running until its last beat
  `SOCD_ASSERT_NEXT(a_reply_run, clk, rst, out_valid && tx_valid && !last && !out_stall, out_valid && tx_valid, "reply cut short")

  // stalled beat holds
  `SOCD_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(tx_byte) && $stable(last), "stalled beat changed")

endmodule

bind serial_output_command_decoder socd_checker u_socd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .tx_byte   (tx_byte),
  .tx_valid  (tx_valid),
  .last      (last)
);

`default_nettype wire

### verif/serial_output_command_decoder_tb.sv
// Testbench for serial_output_command_decoder: directed and random byte streams,
// checked beat by beat against a behavioral decoder. Depends on socd_pkg and the RTL.
`default_nettype none

module serial_output_command_decoder_tb;
  import socd_pkg::*;

  // Status reply characters not in the package
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [63:0] STATUS_TEXT =
    {CH_STAR, CH_QRY, CH_DASH, CH_DASH, CH_ONE, CH_ZERO, CH_EIGHT, CH_CR};

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 330;
  localparam int LONG_HOLD      = 80;
  localparam int END_WAIT       = 20;

  typedef struct packed {
    logic [5:0] bits;
    logic       txv;
    logic [7:0] txb;
    logic       lst;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       tx_ready = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] out_bits;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       last;

  serial_output_command_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .tx_ready  (tx_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bits  (out_bits),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte),
    .last      (last)
  );

  always #4 clk = ~clk;

  // Decoder state mirror
  set_phase_t   set_ph;
  query_phase_t qry_ph;
  logic [3:0]   sel_ch;
  logic         lvl;
  logic [5:0]   out_state;
  out_beat_t    decoder_beats[$];

  bit failed = 1'b0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit sender_gaps = 1'b0;
  int burst_left = 0;
  int bytes_sent = 0;

  // Advance both recognizers by one byte and queue the beats it produces
  function automatic void decode_rx_byte(input logic [7:0] b, input logic rdy);
    out_beat_t  beat;
    logic       reply;
    logic [3:0] pair;
    int         k;
    reply = 1'b0;
    case (set_ph)
      SET_STAR:  set_ph = (b == CH_SET) ? SET_CHAN : SET_IDLE;
      SET_CHAN: begin
        sel_ch = b[3:0];
        set_ph = SET_LEVEL;
      end
      SET_LEVEL: begin
        lvl = b[0];
        set_ph = SET_TERM;
      end
      SET_TERM: begin
        if (b == CH_CR) begin
          if (sel_ch == 4'd0) begin
            out_state[0] = lvl;
          end else if (sel_ch == 4'd1) begin
            out_state[1] = lvl;
          end else if (sel_ch <= 4'd5) begin
            pair = sel_ch - 4'd2;
            out_state[3:2] = pair[1:0];
          end else if (sel_ch <= 4'd9) begin
            pair = sel_ch - 4'd6;
            out_state[5:4] = pair[1:0];
          end
        end
        set_ph = SET_IDLE;
      end
      default:   set_ph = (b == CH_STAR) ? SET_STAR : SET_IDLE;
    endcase
    case (qry_ph)
      QRY_STAR: qry_ph = (b == CH_QRY) ? QRY_TERM : QRY_IDLE;
      QRY_TERM: begin
        reply = (b == CH_CR);
        qry_ph = QRY_IDLE;
      end
      default:  qry_ph = (b == CH_STAR) ? QRY_STAR : QRY_IDLE;
    endcase
    if (reply && rdy) begin
      for (k = 0; k < REPLY_LEN; k++) begin
        beat.bits = out_state;
        beat.txv  = 1'b1;
        beat.txb  = STATUS_TEXT[63 - 8 * k -: 8];
        beat.lst  = (k == REPLY_LEN - 1);
        decoder_beats.push_back(beat);
      end
    end else begin
      beat.bits = out_state;
      beat.txv  = 1'b0;
      beat.txb  = 8'h00;
      beat.lst  = 1'b1;
      decoder_beats.push_back(beat);
    end
  endfunction

  // Monitor: input beats first, then output beats, so the order is fixed
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      set_ph = SET_IDLE;
      qry_ph = QRY_IDLE;
      sel_ch = 4'd0;
      lvl = 1'b0;
      out_state = 6'd0;
      quiet_cycles = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_rx_byte(rx_byte, tx_ready);
      end
      if (out_valid && !out_stall) begin
        if (decoder_beats.size() == 0) begin
          $display("%0t: unexpected beat out_bits=%h tx_valid=%b tx_byte=%h last=%b",
                   $time, out_bits, tx_valid, tx_byte, last);
          failed = 1'b1;
        end else begin
          want = decoder_beats.pop_front();
          if (out_bits !== want.bits) begin
            $display("%0t: out_bits expected %h actual %h", $time, want.bits, out_bits);
            failed = 1'b1;
          end
          if (tx_valid !== want.txv) begin
            $display("%0t: tx_valid expected %b actual %b", $time, want.txv, tx_valid);
            failed = 1'b1;
          end
          if (tx_byte !== want.txb) begin
            $display("%0t: tx_byte expected %h actual %h", $time, want.txb, tx_byte);
            failed = 1'b1;
          end
          if (last !== want.lst) begin
            $display("%0t: last expected %b actual %b", $time, want.lst, last);
            failed = 1'b1;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
    end
  end

  // Watchdog: too long without any beat accepted
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("serial_output_command_decoder_tb failed");
    $finish;
  end

  // Receiver: random stall rate plus long holds
  initial begin
    int pct;
    int cyc;
    pct = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 96 == 0) begin
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 20;
          2:       pct = 50;
          default: pct = 85;
        endcase
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Send one byte; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic rdy);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    tx_ready <= rdy;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sender pauses until every queued beat has come out
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(negedge clk); while (decoder_beats.size() != 0);
  endtask

  task automatic send_set_cmd(input logic [7:0] chan, input logic [7:0] level,
                              input logic [7:0] term);
    send_byte(CH_STAR, 1'($urandom_range(0, 1)));
    send_byte(CH_SET, 1'($urandom_range(0, 1)));
    send_byte(chan, 1'($urandom_range(0, 1)));
    send_byte(level, 1'($urandom_range(0, 1)));
    send_byte(term, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_query_cmd(input logic [7:0] term, input logic rdy);
    send_byte(CH_STAR, 1'($urandom_range(0, 1)));
    send_byte(CH_QRY, 1'($urandom_range(0, 1)));
    send_byte(term, rdy);
  endtask

  // One command per channel group, high nibbles and level bits at extremes
  task automatic test_set_commands();
    sender_gaps = 1'b0;
    send_set_cmd(8'h30, 8'h31, CH_CR);  // channel 0 on
    send_set_cmd(8'hF1, 8'hFF, CH_CR);  // channel 1, high nibble ignored
    send_set_cmd(8'h35, 8'h00, CH_CR);  // lower pair = 3
    send_set_cmd(8'h09, 8'hFE, CH_CR);  // upper pair = 3
    send_set_cmd(8'h3A, 8'h01, CH_CR);  // out of range channel, no change
    drain_outputs();
  endtask

  // Status query with the transmitter ready and busy
  task automatic test_status_query();
    send_query_cmd(CH_CR, 1'b1);
    send_query_cmd(CH_CR, 1'b0);
    drain_outputs();
  endtask

  // Star after star and bad terminators
  task automatic test_malformed();
    send_byte(CH_STAR, 1'b1);
    send_byte(CH_STAR, 1'b1);
    send_byte(CH_SET, 1'b1);
    send_byte(8'h30, 1'b1);
    send_byte(8'h31, 1'b1);
    send_byte(CH_CR, 1'b1);
    send_set_cmd(8'h31, 8'h00, 8'hFF);
    send_query_cmd(8'h00, 1'b1);
    drain_outputs();
  endtask

  // Long receiver hold while the sender keeps offering bytes
  task automatic test_output_backpressure();
    int i;
    sender_gaps = 1'b0;
    hold_left = LONG_HOLD;
    for (i = 0; i < 6; i++) begin
      send_query_cmd(CH_CR, 1'b1);
      send_set_cmd(8'($urandom), 8'($urandom), CH_CR);
    end
    drain_outputs();
  endtask

  // Mostly well-formed commands with random content, some broken ones and noise
  task automatic test_random_stream();
    int stop_at;
    int pick;
    int n;
    int i;
    logic [7:0] bad;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) sender_gaps = ~sender_gaps;
      bad = 8'($urandom);
      if (bad == CH_CR) bad = 8'h00;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_set_cmd(8'($urandom), 8'($urandom), CH_CR);
      end else if (pick < 70) begin
        send_query_cmd(CH_CR, $urandom_range(0, 3) != 0);
      end else if (pick < 76) begin
        send_set_cmd(8'($urandom), 8'($urandom), bad);
      end else if (pick < 80) begin
        // truncated set command
        send_byte(CH_STAR, 1'($urandom_range(0, 1)));
        send_byte(CH_SET, 1'($urandom_range(0, 1)));
        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end else if (pick < 86) begin
        send_query_cmd(bad, 1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
        send_byte(CH_STAR, 1'($urandom_range(0, 1)));
        send_byte(CH_STAR, 1'($urandom_range(0, 1)));
      end else begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end
    drain_outputs();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_set_commands();
    test_status_query();
    test_malformed();
    test_output_backpressure();
    test_random_stream();
    drain_outputs();
    repeat (END_WAIT) @(negedge clk);
    if (decoder_beats.size() != 0) begin
      $display("%0t: %0d beats never arrived", $time, decoder_beats.size());
    end
    if (!failed && decoder_beats.size() == 0) begin
      $display("serial_output_command_decoder_tb passed");
    end else begin
      $display("serial_output_command_decoder_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
